// ----- rtl/stt_pkg.sv -----
// ----------------------------------------------------------------------------
// stt_pkg: shared definitions for the software timer table
// Request and result codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int HANDLE_W = 32;
  localparam int VALUE_W  = 32;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_CANCEL = 3'd1,
    KIND_QUERY  = 3'd2,
    KIND_FIRE   = 3'd3,
    KIND_DONE   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE,
    ST_READ,
    ST_LOOK,
    ST_ADD,
    ST_CMP,
    ST_EMIT
  } state_t;

  // One result beat waiting to go to the output register.
  typedef struct packed {
    kind_t                kind;
    logic [HANDLE_W-1:0]  handle;
    logic                 status;
    logic                 live;
    logic                 last;
  } result_t;

endpackage

// ----- rtl/software_timer_table.sv -----
// ----------------------------------------------------------------------------
// software_timer_table: table of one-shot and periodic software timers
// Add, cancel, query and tick requests over a small slot store, one slot
// visited per step by a shared adder and comparator.
// ----------------------------------------------------------------------------
// A request is one input beat; its answer is one output beat, except a tick,
// which gives one fire beat per expiring timer (in slot order) and then a
// tick-done beat with tlast high. The block takes one request at a time and
// drops s_tready until the last result beat has been loaded into the output
// register. Timing is set by a walk over the slots. An add steps over the used
// slots below the first free one, writes the timer there and loads the output;
// when the table is full it visits every slot. A cancel or query skips unused
// slots, reads and compares each used slot it visits, stops at the first match
// and then loads the output. A tick skips unused slots; for each used slot it
// does a memory read, a saturating add and a compare and subtract; each firing
// timer adds an output load, and tick-done is loaded last. The walk stalls
// while a result waits on a held output register (m_tvalid high, m_tready low).
// A tick while enable is low skips the walk and goes straight to the tick-done
// load. Slot occupancy bits are cleared by reset itself, so no clearing pass
// runs; the timer store's read data is only used for occupied slots.
module software_timer_table
  import stt_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Configuration: enable register.
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  // Request stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // delay_value[31:0], repeat_req[32], count_frames[33],
  // target_handle[65:34], elapsed_us[97:66], zero fill [103:98]
  input  logic [103:0] s_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_tuser,
  // Result stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // handle_out[31:0], status[32], live[33], zero fill [39:34]
  output logic [39:0]  m_tdata,
  // result_kind[2:0]
  output logic [2:0]   m_tuser,
  output logic         m_tlast
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  // The adder is wide enough for either operand plus a carry.
  localparam int SW = ((TIME_BITS > VALUE_W) ? TIME_BITS : VALUE_W) + 1;
  localparam logic [SW-1:0] TMAX_W = {{(SW-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

  // Control state.
  state_t               state, state_next;
  logic [IW-1:0]        idx, idx_next;
  logic                 enable;
  logic [SLOTS-1:0]     used;
  logic [HANDLE_W-1:0]  next_handle;
  result_t              res, res_next;

  // Latched request fields.
  req_t                 req;
  logic [VALUE_W-1:0]   delay_in;
  logic                 rep_in;
  logic                 frm_in;
  logic [HANDLE_W-1:0]  target;
  logic [VALUE_W-1:0]   elapsed;

  // Timer store, read through registers at the walk index.
  logic [HANDLE_W-1:0]  handle_mem [SLOTS];
  logic [TIME_BITS-1:0] delay_mem  [SLOTS];
  logic [TIME_BITS-1:0] accum_mem  [SLOTS];
  logic                 rep_mem    [SLOTS];
  logic                 frm_mem    [SLOTS];
  logic [HANDLE_W-1:0]  handle_rd;
  logic [TIME_BITS-1:0] delay_rd;
  logic [TIME_BITS-1:0] accum_rd;
  logic                 rep_rd;
  logic                 frm_rd;

  // Shared arithmetic.
  logic [TIME_BITS-1:0] acc, acc_next;
  logic [SW-1:0]        sum_w;
  logic [SW-1:0]        dly_w;
  logic [TIME_BITS-1:0] dly_sat;
  logic                 fire;

  // Strobes from the sequencer.
  logic                 accept;
  logic                 add_we;
  logic                 acc_we;
  logic [TIME_BITS-1:0] acc_wdata;
  logic                 used_set;
  logic                 used_clr;
  logic                 load_out;
  logic                 step;
  logic [HANDLE_W-1:0]  nh_inc;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Saturating accumulate: one frame, or the elapsed microseconds.
  always_comb begin
    sum_w = SW'(accum_rd) + (frm_rd ? SW'(1) : SW'(elapsed));
    if (sum_w > TMAX_W) begin
      sum_w = TMAX_W;
    end
  end

  // A delay beyond the time width is kept as the largest time.
  always_comb begin
    dly_w   = SW'(delay_in);
    dly_sat = (dly_w > TMAX_W) ? TMAX_W[TIME_BITS-1:0] : dly_w[TIME_BITS-1:0];
  end

  assign fire   = (acc >= delay_rd);
  assign nh_inc = next_handle + HANDLE_W'(1);

  // Sequencer: next state, walk index, pending result and strobes.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    res_next   = res;
    acc_next   = acc;
    add_we     = 1'b0;
    acc_we     = 1'b0;
    acc_wdata  = '0;
    used_set   = 1'b0;
    used_clr   = 1'b0;
    load_out   = 1'b0;
    step       = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          idx_next = '0;
          case (req_t'(s_tuser))
            REQ_ADD:    state_next = ST_FREE;
            REQ_CANCEL: state_next = ST_READ;
            REQ_QUERY:  state_next = ST_READ;
            REQ_TICK: begin
              if (enable) begin
                state_next = ST_READ;
              end else begin
                res_next   = '{kind: KIND_DONE, handle: '0, status: 1'b0,
                               live: 1'b0, last: 1'b1};
                state_next = ST_EMIT;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end

      ST_FREE: begin
        if (!used[idx]) begin
          add_we     = 1'b1;
          used_set   = 1'b1;
          res_next   = '{kind: KIND_ADD, handle: next_handle, status: 1'b0,
                         live: 1'b0, last: 1'b1};
          state_next = ST_EMIT;
        end else begin
          step = 1'b1;
        end
      end

      ST_READ: begin
        if (!used[idx]) begin
          step = 1'b1;
        end else if (req == REQ_TICK) begin
          state_next = ST_ADD;
        end else begin
          state_next = ST_LOOK;
        end
      end

      ST_LOOK: begin
        if (handle_rd == target) begin
          used_clr   = (req == REQ_CANCEL);
          res_next   = '{kind: (req == REQ_CANCEL) ? KIND_CANCEL : KIND_QUERY,
                         handle: target, status: 1'b0,
                         live: (req == REQ_QUERY), last: 1'b1};
          state_next = ST_EMIT;
        end else begin
          step = 1'b1;
        end
      end

      ST_ADD: begin
        acc_next   = sum_w[TIME_BITS-1:0];
        state_next = ST_CMP;
      end

      ST_CMP: begin
        acc_we = 1'b1;
        if (fire) begin
          acc_wdata  = frm_rd ? '0 : (acc - delay_rd);
          used_clr   = !rep_rd;
          res_next   = '{kind: KIND_FIRE, handle: handle_rd, status: 1'b0,
                         live: 1'b0, last: 1'b0};
          state_next = ST_EMIT;
        end else begin
          acc_wdata = acc;
          step      = 1'b1;
        end
      end

      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          load_out = 1'b1;
          if (res.last) begin
            state_next = ST_IDLE;
          end else begin
            step = 1'b1;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase

    // Move to the next slot, or close the walk with the final answer.
    if (step) begin
      if (idx == LAST_IDX) begin
        case (req)
          REQ_ADD:    res_next = '{kind: KIND_ADD, handle: '0, status: 1'b1,
                                   live: 1'b0, last: 1'b1};
          REQ_CANCEL: res_next = '{kind: KIND_CANCEL, handle: target, status: 1'b0,
                                   live: 1'b0, last: 1'b1};
          REQ_QUERY:  res_next = '{kind: KIND_QUERY, handle: target, status: 1'b0,
                                   live: 1'b0, last: 1'b1};
          default:    res_next = '{kind: KIND_DONE, handle: '0, status: 1'b0,
                                   live: 1'b0, last: 1'b1};
        endcase
        state_next = ST_EMIT;
      end else begin
        idx_next   = idx + IW'(1);
        state_next = (req == REQ_ADD) ? ST_FREE : ST_READ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      enable      <= 1'b0;
      used        <= '0;
      next_handle <= HANDLE_W'(1);
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg_we) begin
        enable <= cfg_wdata;
      end
      if (used_set) begin
        used[idx]   <= 1'b1;
        next_handle <= (nh_inc == '0) ? HANDLE_W'(1) : nh_inc;
      end else if (used_clr) begin
        used[idx] <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    res <= res_next;
    acc <= acc_next;
    if (accept) begin
      req      <= req_t'(s_tuser);
      delay_in <= s_tdata[31:0];
      rep_in   <= s_tdata[32];
      frm_in   <= s_tdata[33];
      target   <= s_tdata[65:34];
      elapsed  <= s_tdata[97:66];
    end
    if (load_out) begin
      m_tuser <= res.kind;
      m_tdata <= {6'd0, res.live, res.status, res.handle};
      m_tlast <= res.last;
    end
  end

  // Timer store.
  always_ff @(posedge clk) begin
    if (add_we) begin
      handle_mem[idx] <= next_handle;
      delay_mem[idx]  <= dly_sat;
      rep_mem[idx]    <= rep_in;
      frm_mem[idx]    <= frm_in;
    end
    if (add_we || acc_we) begin
      accum_mem[idx] <= add_we ? '0 : acc_wdata;
    end
    handle_rd <= handle_mem[idx];
    delay_rd  <= delay_mem[idx];
    accum_rd  <= accum_mem[idx];
    rep_rd    <= rep_mem[idx];
    frm_rd    <= frm_mem[idx];
  end

endmodule
